// ----- src/assert_macros.svh -----
// Assertion macros for the RTL file of the servo sweep block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SSBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define SSBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- src/ssbt_pkg.sv -----
// Package: word types, codes and constants of the servo sweep block
`default_nettype none

package ssbt_pkg;

  // Operation codes
  localparam logic [1:0] OpSweep  = 2'd0;
  localparam logic [1:0] OpButton = 2'd1;
  localparam logic [1:0] OpArm    = 2'd2;

  // Button state codes
  localparam logic [2:0] BtnNone       = 3'd0;
  localparam logic [2:0] BtnTop        = 3'd1;
  localparam logic [2:0] BtnBottom     = 3'd2;
  localparam logic [2:0] BtnBoth       = 3'd3;
  localparam logic [2:0] BtnTopRel     = 3'd4;
  localparam logic [2:0] BtnBottomRel  = 3'd5;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgSweepStep   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCentrePos   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCentreIn    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStartTop    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStartBottom = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStartDiv    = 3'd5;

  // Fixed constants
  localparam logic [15:0] AmpHigh    = 16'd5000;
  localparam logic [15:0] AmpLow     = 16'd1000;
  localparam logic [15:0] AmpDelta   = 16'd40;
  localparam logic [7:0]  DivCeil    = 8'd200;
  localparam logic [7:0]  DivStep    = 8'd2;
  localparam logic [15:0] HoldReload = 16'd150;
  localparam logic [15:0] PosReset   = 16'd3000;

  // Register reset values
  localparam logic [15:0] RstSweepStep   = 16'd40;
  localparam logic [15:0] RstCentrePos   = 16'd3000;
  localparam logic [15:0] RstCentreIn    = 16'd3000;
  localparam logic [12:0] RstStartTop    = 13'd4000;
  localparam logic [15:0] RstStartBottom = 16'd2000;
  localparam logic [7:0]  RstStartDiv    = 8'd20;

  // Input word
  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  button_state;
    logic [15:0] input_width;
    logic [15:0] repeat_load;
  } ssbt_in_t;

  // Result word
  typedef struct packed {
    logic [15:0] position;
    logic [15:0] top_limit;
    logic [15:0] bottom_limit;
    logic [7:0]  divider_value;
    logic        rising;
  } ssbt_out_t;

endpackage

`default_nettype wire

// ----- src/ssbt_in_if.sv -----
// Valid/ready channel carrying input words
`default_nettype none

interface ssbt_in_if import ssbt_pkg::*; ();
  logic     valid;
  logic     ready;
  ssbt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ssbt_out_if.sv -----
// Valid/ready channel carrying result words
`default_nettype none

interface ssbt_out_if import ssbt_pkg::*; ();
  logic      valid;
  logic      ready;
  ssbt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/servo_sweep_with_button_trim.sv -----
// Top level: servo triangle sweep with button trim of amplitude and divider
//
//   channel  dir  handshake          word
//   in_ch    in   valid/ready        operation, button_state, input_width, repeat_load
//   out_ch   out  valid/ready        position, top/bottom limit, divider, rising
//   cfg_*    in   write enable only  index 0..5, 16-bit data
//
// One word in, one result word out; an input word is taken every cycle while
// the skid register is empty. The state update runs in the cycle of acceptance;
// the result goes to the output register, or, when the output stalls, to a skid
// register holding one extra result; input stalls only when both are occupied.
// Reset (rst_n low, synchronous) loads position 3000, direction down,
// the start limits and divider, and clears the repeat counter.
`default_nettype none

`include "assert_macros.svh"

module servo_sweep_with_button_trim import ssbt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  ssbt_in_if.sink                 in_ch,
  ssbt_out_if.source              out_ch,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  // Configuration registers
  logic [15:0] sweep_step_r;
  logic [15:0] centre_pos_r;
  logic [15:0] centre_in_r;
  logic [12:0] start_top_r;
  logic [15:0] start_bottom_r;
  logic [7:0]  start_div_r;

  // Block state
  logic [15:0] position_r, position_nxt;
  logic        rising_r, rising_nxt;
  logic [15:0] top_r, top_nxt;
  logic [15:0] bottom_r, bottom_nxt;
  logic [7:0]  div_r, div_nxt;
  logic [15:0] repeat_r, repeat_nxt;

  // Output and skid registers
  ssbt_out_t   out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  logic        in_fire, out_fire, out_free;
  logic [15:0] sweep_pos;
  logic [15:0] repeat_dec;
  logic        low_in;
  ssbt_out_t   result;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Sweep and button datapath
  assign sweep_pos  = rising_r ? (position_r + sweep_step_r) : (position_r - sweep_step_r);
  assign repeat_dec = repeat_r - 16'd1;
  assign low_in     = in_ch.data.input_width < centre_in_r;

  always_comb begin
    position_nxt = position_r;
    rising_nxt   = rising_r;
    top_nxt      = top_r;
    bottom_nxt   = bottom_r;
    div_nxt      = div_r;
    repeat_nxt   = repeat_r;
    case (in_ch.data.operation)
      OpSweep: begin
        position_nxt = sweep_pos;
        if (!rising_r && sweep_pos <= bottom_r) begin
          rising_nxt = 1'b1;
        end else if (rising_r && sweep_pos >= top_r) begin
          rising_nxt = 1'b0;
        end
      end
      OpButton: begin
        repeat_nxt = repeat_dec;
        if (repeat_dec == 16'd0) begin
          case (in_ch.data.button_state)
            BtnTopRel, BtnBottomRel: begin
              if (low_in) begin
                position_nxt = centre_pos_r;
              end
            end
            BtnTop: begin
              repeat_nxt = HoldReload;
              if (low_in) begin
                if (top_r < AmpHigh) begin
                  top_nxt      = top_r + AmpDelta;
                  bottom_nxt   = bottom_r - AmpDelta;
                  position_nxt = top_r + AmpDelta;
                end
              end else if (div_r > 8'd1) begin
                div_nxt = div_r - DivStep;
              end
            end
            BtnBottom: begin
              repeat_nxt = HoldReload;
              if (low_in) begin
                if (top_r > AmpLow) begin
                  top_nxt      = top_r - AmpDelta;
                  bottom_nxt   = bottom_r + AmpDelta;
                  position_nxt = top_r - AmpDelta;
                end
              end else if (div_r < DivCeil) begin
                div_nxt = div_r + DivStep;
              end
            end
            BtnBoth: begin
              position_nxt = top_r;
            end
            default: begin
            end
          endcase
        end
      end
      OpArm: begin
        repeat_nxt = in_ch.data.repeat_load;
      end
      default: begin
      end
    endcase
  end

  assign result = '{position:      position_nxt,
                    top_limit:     top_nxt,
                    bottom_limit:  bottom_nxt,
                    divider_value: div_nxt,
                    rising:        rising_nxt};

  // Configuration and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_step_r   <= RstSweepStep;
      centre_pos_r   <= RstCentrePos;
      centre_in_r    <= RstCentreIn;
      start_top_r    <= RstStartTop;
      start_bottom_r <= RstStartBottom;
      start_div_r    <= RstStartDiv;
      position_r     <= PosReset;
      rising_r       <= 1'b0;
      top_r          <= {3'd0, RstStartTop};
      bottom_r       <= RstStartBottom;
      div_r          <= RstStartDiv;
      repeat_r       <= 16'd0;
    end else begin
      if (in_fire) begin
        position_r <= position_nxt;
        rising_r   <= rising_nxt;
        top_r      <= top_nxt;
        bottom_r   <= bottom_nxt;
        div_r      <= div_nxt;
        repeat_r   <= repeat_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CfgSweepStep: sweep_step_r <= cfg_wdata;
          CfgCentrePos: centre_pos_r <= cfg_wdata;
          CfgCentreIn:  centre_in_r  <= cfg_wdata;
          CfgStartTop: begin
            start_top_r <= cfg_wdata[12:0];
            top_r       <= {3'd0, cfg_wdata[12:0]};
          end
          CfgStartBottom: begin
            start_bottom_r <= cfg_wdata;
            bottom_r       <= cfg_wdata;
          end
          CfgStartDiv: begin
            start_div_r <= cfg_wdata[7:0];
            div_r       <= cfg_wdata[7:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= in_fire || skid_valid_r;
      end
      if (out_free && skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else if (in_fire && !out_free) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : result;
    end
    if (in_fire && !out_free) begin
      skid_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Checks
  `SSBT_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `SSBT_ASSERT_NXT(a_stall_fills_skid, clk, rst_n,
                   in_fire && out_valid_r && !out_ch.ready, skid_valid_r)
  `SSBT_ASSERT_NXT(a_sweep_keeps_limits, clk, rst_n,
                   in_fire && !cfg_we && in_ch.data.operation == OpSweep,
                   top_r == $past(top_r) && bottom_r == $past(bottom_r))
  `SSBT_ASSERT_NXT(a_accept_gives_result, clk, rst_n, in_fire, out_valid_r)

  logic unused_start;
  assign unused_start = ^{start_top_r, start_bottom_r, start_div_r, out_fire};

endmodule

`default_nettype wire

// ----- tb/sv/tb_servo_sweep_with_button_trim.sv -----
// Testbench for the servo sweep block: random and directed words checked against a built-in model
`default_nettype none

module tb_servo_sweep_with_button_trim;
  timeunit 1ns;
  timeprecision 1ps;
  import ssbt_pkg::*;

  // Codes the package leaves out
  localparam logic [1:0] OpUndefined  = 2'd3;
  localparam logic [2:0] BtnUndefLow  = 3'd6;
  localparam logic [2:0] BtnUndefHigh = 3'd7;

  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned QuietLimit     = 4000;
  localparam int unsigned TailCycles     = 8;
  localparam int unsigned PhaseWords     = 280;

  typedef enum logic [1:0] {RxFree, RxCoin, RxMostly, RxSparse} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  ssbt_in_if  in_ch ();
  ssbt_out_if out_ch ();

  servo_sweep_with_button_trim u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Model copy of the settings and the servo state
  logic [15:0] cfg_sweep_step;
  logic [15:0] cfg_centre_pos;
  logic [15:0] cfg_centre_in;
  logic [12:0] cfg_start_top;
  logic [15:0] cfg_start_bottom;
  logic [7:0]  cfg_start_div;
  logic [15:0] srv_position;
  logic        srv_rising;
  logic [15:0] srv_top;
  logic [15:0] srv_bottom;
  logic [7:0]  srv_divider;
  logic [15:0] srv_repeat;

  ssbt_out_t   servo_results_due [$];
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned settings_loaded;
  int unsigned burst_left;
  int          errors;

  // Receiver side state
  rx_mode_t    rx_mode;
  int unsigned rx_phase_left;
  int unsigned rx_hold_left;
  int unsigned stall_req;
  int unsigned stall_ack;
  int unsigned quiet_cycles;

  task automatic reset_servo_model();
    cfg_sweep_step   = RstSweepStep;
    cfg_centre_pos   = RstCentrePos;
    cfg_centre_in    = RstCentreIn;
    cfg_start_top    = RstStartTop;
    cfg_start_bottom = RstStartBottom;
    cfg_start_div    = RstStartDiv;
    srv_position     = PosReset;
    srv_rising       = 1'b0;
    srv_top          = {3'b000, RstStartTop};
    srv_bottom       = RstStartBottom;
    srv_divider      = RstStartDiv;
    srv_repeat       = '0;
  endtask

  // Applies one input word to the model state and returns the servo status after it
  function automatic ssbt_out_t advance_servo_model(ssbt_in_t w);
    ssbt_out_t   r;
    logic [15:0] p;
    logic        low_in;
    low_in = w.input_width < cfg_centre_in;
    case (w.operation)
      OpSweep: begin
        p = srv_position;
        if (!srv_rising) begin
          p = p - cfg_sweep_step;
          if (p <= srv_bottom) srv_rising = 1'b1;
        end else begin
          p = p + cfg_sweep_step;
          if (p >= srv_top) srv_rising = 1'b0;
        end
        srv_position = p;
      end
      OpButton: begin
        srv_repeat = srv_repeat - 16'd1;
        if (srv_repeat == '0) begin
          case (w.button_state)
            BtnTopRel, BtnBottomRel: begin
              if (low_in) srv_position = cfg_centre_pos;
            end
            BtnTop: begin
              srv_repeat = HoldReload;
              if (low_in) begin
                if (srv_top < AmpHigh) begin
                  srv_top      = srv_top + AmpDelta;
                  srv_bottom   = srv_bottom - AmpDelta;
                  srv_position = srv_top;
                end
              end else if (srv_divider > 8'd1) begin
                srv_divider = srv_divider - DivStep;
              end
            end
            BtnBottom: begin
              srv_repeat = HoldReload;
              if (low_in) begin
                if (srv_top > AmpLow) begin
                  srv_top      = srv_top - AmpDelta;
                  srv_bottom   = srv_bottom + AmpDelta;
                  srv_position = srv_top;
                end
              end else if (srv_divider < DivCeil) begin
                srv_divider = srv_divider + DivStep;
              end
            end
            BtnBoth: srv_position = srv_top;
            default: ;
          endcase
        end
      end
      OpArm: srv_repeat = w.repeat_load;
      default: ;
    endcase
    r.position      = srv_position;
    r.top_limit     = srv_top;
    r.bottom_limit  = srv_bottom;
    r.divider_value = srv_divider;
    r.rising        = srv_rising;
    return r;
  endfunction

  function automatic ssbt_in_t make_word(logic [1:0] op, logic [2:0] btn,
                                         logic [15:0] width, logic [15:0] load);
    ssbt_in_t w;
    w.operation    = op;
    w.button_state = btn;
    w.input_width  = width;
    w.repeat_load  = load;
    return w;
  endfunction

  // Pulse width clustered around the split point, with some fully random ones
  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 4))
      0:       return cfg_centre_in;
      1:       return cfg_centre_in - 16'd1;
      2:       return (cfg_centre_in == '0) ? 16'd0
                      : 16'($urandom_range(0, cfg_centre_in - 1));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Sender gaps: bursts of random length between random pauses
  task automatic pace_sender(bit with_gaps);
    int unsigned gap;
    if (with_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Offers one word, waits for acceptance and books its expected result
  task automatic send_word(ssbt_in_t w, bit with_gaps);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    servo_results_due.push_back(advance_servo_model(w));
    words_sent++;
    pace_sender(with_gaps);
  endtask

  task automatic arm_and_tick(logic [2:0] btn, logic [15:0] width);
    send_word(make_word(OpArm, BtnNone, 16'h0000, 16'd1), 1'b0);
    send_word(make_word(OpButton, btn, width, 16'h0000), 1'b0);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (servo_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes all six registers while the block is idle; start values preload the state
  task automatic load_settings(logic [15:0] step_size, logic [15:0] cpos, logic [15:0] cin,
                               logic [12:0] top, logic [15:0] bottom, logic [7:0] div);
    drain_results();
    write_reg(CfgSweepStep, step_size);
    write_reg(CfgCentrePos, cpos);
    write_reg(CfgCentreIn, cin);
    write_reg(CfgStartTop, {3'b000, top});
    write_reg(CfgStartBottom, bottom);
    write_reg(CfgStartDiv, {8'h00, div});
    cfg_we <= 1'b0;
    cfg_sweep_step   = step_size;
    cfg_centre_pos   = cpos;
    cfg_centre_in    = cin;
    cfg_start_top    = top;
    cfg_start_bottom = bottom;
    cfg_start_div    = div;
    srv_top          = {3'b000, top};
    srv_bottom       = bottom;
    srv_divider      = div;
    settings_loaded++;
  endtask

  // Every operation and button code at least once, from the reset settings
  task automatic test_directed_cases();
    // undefined operation with every field high reports the reset state
    send_word(make_word(OpUndefined, BtnUndefHigh, 16'hFFFF, 16'hFFFF), 1'b0);
    send_word(make_word(OpSweep, BtnNone, 16'h0000, 16'h0000), 1'b0);
    // tick at count zero only wraps the counter
    send_word(make_word(OpButton, BtnTop, 16'h0000, 16'h0000), 1'b0);
    arm_and_tick(BtnTop, 16'h0000);
    arm_and_tick(BtnBottom, 16'h0000);
    arm_and_tick(BtnTop, 16'hFFFF);
    arm_and_tick(BtnBottom, cfg_centre_in);
    arm_and_tick(BtnBoth, 16'h0000);
    arm_and_tick(BtnTopRel, cfg_centre_in - 16'd1);
    arm_and_tick(BtnBottomRel, cfg_centre_in);
    // count of two: first tick only counts, second hits an undefined code
    send_word(make_word(OpArm, BtnNone, 16'h0000, 16'd2), 1'b0);
    send_word(make_word(OpButton, BtnNone, 16'h0000, 16'h0000), 1'b0);
    send_word(make_word(OpButton, BtnUndefLow, 16'h0000, 16'h0000), 1'b0);
    repeat (3) send_word(make_word(OpSweep, BtnUndefHigh, 16'h5A5A, 16'hA5A5), 1'b0);
  endtask

  // Amplitude and divider trim at their bounds
  task automatic test_trim_limits();
    load_settings(RstSweepStep, RstCentrePos, RstCentreIn, 13'(AmpHigh), RstStartBottom,
                  DivCeil);
    arm_and_tick(BtnTop, 16'h0000);
    arm_and_tick(BtnBottom, 16'hFFFF);
    arm_and_tick(BtnTop, 16'hFFFF);
    arm_and_tick(BtnBottom, 16'h0000);
    load_settings(RstSweepStep, RstCentrePos, RstCentreIn, 13'(AmpLow), RstStartBottom, 8'd1);
    arm_and_tick(BtnBottom, 16'h0000);
    arm_and_tick(BtnTop, 16'hFFFF);
    arm_and_tick(BtnTop, 16'h0000);
    send_word(make_word(OpSweep, BtnNone, 16'h0000, 16'h0000), 1'b0);
  endtask

  // Held button: the reload of the counter brings a second trim 150 ticks later
  task automatic test_hold_repeat();
    load_settings(RstSweepStep, RstCentrePos, RstCentreIn, RstStartTop, RstStartBottom,
                  RstStartDiv);
    send_word(make_word(OpArm, BtnNone, 16'h0000, 16'd1), 1'b1);
    repeat (HoldReload + 1)
      send_word(make_word(OpButton, BtnTop, 16'($urandom_range(0, RstCentreIn - 1)),
                          16'($urandom)), 1'b1);
  endtask

  // Long output stall while words keep coming, then a full drain
  task automatic test_backpressure();
    drain_results();
    stall_req <= stall_req + 1;
    repeat (24)
      send_word(make_word(2'($urandom_range(0, 2)), 3'($urandom_range(0, 7)), pick_width(),
                          16'($urandom_range(0, 3))), 1'b0);
    drain_results();
  endtask

  // Mostly arm/tick sequences that reach zero, sweep runs, and some raw noise
  task automatic run_random_phase(int unsigned n, bit with_gaps);
    int unsigned first;
    int unsigned kind;
    int unsigned k;
    int unsigned btn_pick;
    logic [15:0] load;
    first = words_sent;
    while (words_sent - first < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        k = $urandom_range(1, 10);
        repeat (k)
          send_word(make_word(OpSweep, 3'($urandom_range(0, 7)), 16'($urandom),
                              16'($urandom)), with_gaps);
      end else if (kind < 9) begin
        if ($urandom_range(0, 7) == 0) load = 16'($urandom);
        else load = 16'($urandom_range(0, 4));
        send_word(make_word(OpArm, 3'($urandom_range(0, 7)), 16'($urandom), load),
                  with_gaps);
        k = (load == '0 || load > 16'd4) ? $urandom_range(1, 3) : {16'd0, load};
        repeat (k - 1)
          send_word(make_word(OpButton, 3'($urandom_range(0, 7)), pick_width(),
                              16'($urandom)), with_gaps);
        btn_pick = $urandom_range(0, 9);
        if (btn_pick == 8) btn_pick = 32'(BtnTop);
        if (btn_pick == 9) btn_pick = 32'(BtnBottom);
        send_word(make_word(OpButton, 3'(btn_pick), pick_width(), 16'($urandom)),
                  with_gaps);
      end else begin
        send_word(make_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                            16'($urandom), 16'($urandom)), with_gaps);
      end
    end
  endtask

  // Reset values, both extremes, then random settings
  task automatic test_random_settings();
    int unsigned idx;
    for (idx = 0; idx < 5; idx++) begin
      case (idx)
        0: load_settings(RstSweepStep, RstCentrePos, RstCentreIn, RstStartTop,
                         RstStartBottom, RstStartDiv);
        1: load_settings(16'hFFFF, 16'h0000, 16'h0000, 13'(AmpLow), 16'h0000, 8'd0);
        2: load_settings(16'h0000, 16'hFFFF, 16'hFFFF, 13'(AmpHigh), 16'hFFFF,
                         DivCeil + 8'd1);
        default: load_settings(16'($urandom_range(1, 600)), 16'($urandom),
                               16'($urandom_range(500, 6000)),
                               13'($urandom_range(AmpLow, AmpHigh)), 16'($urandom),
                               8'($urandom_range(0, DivCeil + 1)));
      endcase
      run_random_phase(PhaseWords, idx % 2 == 0);
    end
  endtask

  // Receiver: ready pattern switches between random modes; long hold on request
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (stall_req != stall_ack) begin
      out_ch.ready <= 1'b0;
      stall_ack    <= stall_req;
      rx_hold_left <= LongHoldCycles;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       <= rx_mode_t'($urandom_range(0, 3));
        rx_phase_left <= $urandom_range(20, 120);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_mode)
        RxFree:   out_ch.ready <= 1'b1;
        RxCoin:   out_ch.ready <= 1'($urandom_range(0, 1));
        RxMostly: out_ch.ready <= ($urandom_range(0, 7) != 0);
        default:  out_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_checker
    ssbt_out_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (servo_results_due.size() == 0) begin
        errors++;
        $display("%0t ns: result word with nothing expected: expected none, got %p",
                 $time, out_ch.data);
      end else begin
        want = servo_results_due.pop_front();
        results_checked++;
        check_field("position", want.position, out_ch.data.position);
        check_field("top_limit", want.top_limit, out_ch.data.top_limit);
        check_field("bottom_limit", want.bottom_limit, out_ch.data.bottom_limit);
        check_field("divider_value", want.divider_value, out_ch.data.divider_value);
        check_field("rising", want.rising, out_ch.data.rising);
      end
    end
  end

  // Watchdog on cycles with no word moving on any port
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || cfg_we === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
               $time, QuietLimit, servo_results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    reset_servo_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_trim_limits();
    test_hold_repeat();
    test_backpressure();
    test_random_settings();

    // drain, then let the pipeline settle
    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (servo_results_due.size() != 0) begin
      errors += servo_results_due.size();
      $display("%0t ns: %0d results never arrived, first expected %p",
               $time, servo_results_due.size(), servo_results_due[0]);
    end

    $display("Sent %0d words over %0d register settings: every operation and button code,",
             words_sent, settings_loaded + 1);
    $display("trim limits, a held button, a long output stall; %0d results checked, %0d errors",
             results_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/ssbt_pkg.sv
src/ssbt_in_if.sv
src/ssbt_out_if.sv
src/servo_sweep_with_button_trim.sv
tb/sv/tb_servo_sweep_with_button_trim.sv
